/* hw/rtl/ocov_pkg.sv */
// ocov_pkg: shared types, constants and arithmetic helpers for the 3-d online covariance block
// no dependencies; imported by every module of the block but the checker
package ocov_pkg;

    localparam int COUNT_WIDTH_DEF = 20;
    localparam int NUM_AXES        = 3;
    localparam int SAMPLE_W        = 32;
    localparam int MEAN_W          = 48;
    localparam int DELTA_W         = 49;
    localparam int COV_W           = 64;
    localparam int CNT_OUT_W       = 20;
    localparam int S_DATA_W        = 96;
    localparam int M_DATA_W        = 248;

    localparam logic CMD_ADD   = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    localparam logic [1:0] ROW_LAST = 2'd2;

    typedef enum logic [2:0] {
        LS_IDLE,
        LS_MDIV,
        LS_D2,
        LS_MWAIT,
        LS_MUL,
        LS_MFIN,
        LS_MDONE,
        LS_CDIV
    } lane_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_ADD,
        T_MEANW,
        T_MULW,
        T_COV,
        T_COVW
    } top_state_t;

    typedef struct packed {
        logic add;
        logic clr;
        logic mul;
        logic cov;
        logic valid;
    } lane_ctl_t;

    typedef struct packed {
        logic mean_rdy;
        logic mul_done;
        logic idle;
    } lane_stat_t;

    // magnitude of a delta, fits unsigned in the same width
    function automatic logic [DELTA_W-1:0] mag_delta(input logic signed [DELTA_W-1:0] v);
        mag_delta = v[DELTA_W-1] ? DELTA_W'(-v) : DELTA_W'(v);
    endfunction

    function automatic logic [COV_W-1:0] mag_cov(input logic signed [COV_W-1:0] v);
        mag_cov = v[COV_W-1] ? COV_W'(-v) : COV_W'(v);
    endfunction

    // signed value from sign and magnitude, saturated to 64 bits
    function automatic logic signed [COV_W-1:0] sat_mag(input logic neg,
                                                        input logic [COV_W+1:0] m);
        logic signed [COV_W-1:0] r;
        if (neg) begin
            if (m[COV_W+1:COV_W-1] != 3'b000) begin
                r = {1'b1, {(COV_W-1){1'b0}}};
            end else begin
                r = -$signed(m[COV_W-1:0]);
            end
        end else begin
            if (m[COV_W+1:COV_W-1] != 3'b000) begin
                r = {1'b0, {(COV_W-1){1'b1}}};
            end else begin
                r = $signed(m[COV_W-1:0]);
            end
        end
        sat_mag = r;
    endfunction

    function automatic logic signed [COV_W-1:0] sat_add(input logic signed [COV_W-1:0] a,
                                                        input logic signed [COV_W-1:0] b);
        logic signed [COV_W:0] s;
        s = {a[COV_W-1], a} + {b[COV_W-1], b};
        if (s[COV_W] != s[COV_W-1]) begin
            sat_add = s[COV_W] ? {1'b1, {(COV_W-1){1'b0}}} : {1'b0, {(COV_W-1){1'b1}}};
        end else begin
            sat_add = s[COV_W-1:0];
        end
    endfunction

    // q16.32 to q16.16, round half up, saturated
    function automatic logic signed [SAMPLE_W-1:0] round_mean(
        input logic signed [MEAN_W-1:0] m);
        logic signed [MEAN_W:0]   t;
        logic signed [SAMPLE_W:0] q;
        t = {m[MEAN_W-1], m} + (MEAN_W+1)'(32768);
        q = t[MEAN_W:16];
        if (q[SAMPLE_W] != q[SAMPLE_W-1]) begin
            round_mean = q[SAMPLE_W] ? {1'b1, {(SAMPLE_W-1){1'b0}}}
                                     : {1'b0, {(SAMPLE_W-1){1'b1}}};
        end else begin
            round_mean = q[SAMPLE_W-1:0];
        end
    endfunction

endpackage

/* hw/rtl/ocov_div.sv */
// ocov_div: radix-2 restoring divider, 64-bit dividend by a count-wide divisor
// depends on ocov_pkg
module ocov_div #(
    parameter int COUNT_WIDTH = ocov_pkg::COUNT_WIDTH_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   start_i,
    input  logic [63:0]            dividend_i,
    input  logic [COUNT_WIDTH-1:0] divisor_i,
    output logic                   done_o,
    output logic [63:0]            quot_o
);
    import ocov_pkg::*;

    logic                   busy_reg;
    logic                   done_reg;
    logic [5:0]             cnt_reg;
    logic [63:0]            q_reg;
    logic [COUNT_WIDTH-1:0] rem_reg;
    logic [COUNT_WIDTH-1:0] dsr_reg;
    logic [COUNT_WIDTH:0]   trial;
    logic                   ge;
    logic [COUNT_WIDTH-1:0] rem_next;

    always_comb begin
        trial    = {rem_reg, q_reg[63]};
        ge       = (trial >= {1'b0, dsr_reg});
        rem_next = ge ? COUNT_WIDTH'(trial - {1'b0, dsr_reg}) : trial[COUNT_WIDTH-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start_i) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start_i) begin
            q_reg   <= dividend_i;
            rem_reg <= '0;
            dsr_reg <= divisor_i;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[62:0], ge};
            rem_reg <= rem_next;
        end
    end

    assign done_o = done_reg;
    assign quot_o = q_reg;

endmodule

/* hw/rtl/ocov_lane.sv */
// ocov_lane: per-axis core holding one mean and one co-moment row, with its own divider
// depends on ocov_pkg and ocov_div
module ocov_lane #(
    parameter int COUNT_WIDTH = ocov_pkg::COUNT_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ocov_pkg::lane_ctl_t          ctl_i,
    input  logic signed [31:0]           sample_i,
    input  logic [COUNT_WIDTH-1:0]       count_i,
    input  logic signed [48:0]           d2_all_i [3],
    output ocov_pkg::lane_stat_t         stat_o,
    output logic signed [48:0]           d2_o,
    output logic signed [47:0]           mean_o,
    output logic signed [63:0]           cov_o [3]
);
    import ocov_pkg::*;

    lane_state_t             state_reg, state_next;
    logic signed [MEAN_W-1:0]  s_reg, s_next;
    logic signed [DELTA_W-1:0] d1_reg, d1_next;
    logic signed [DELTA_W-1:0] d2_reg, d2_next;
    logic signed [MEAN_W-1:0]  mean_reg, mean_next;
    logic signed [COV_W-1:0]   com_reg [3];
    logic signed [COV_W-1:0]   com_next [3];
    logic signed [COV_W-1:0]   cov_reg [3];
    logic signed [COV_W-1:0]   cov_next [3];
    logic [1:0]              col_reg, col_next;
    logic [2:0]              step_reg, step_next;
    logic [63:0]             pp_reg, pp_next;
    logic [1:0]              sh_reg, sh_next;
    logic [97:0]             acc_reg, acc_next;

    logic                      div_start;
    logic [63:0]               div_dvd;
    logic [COUNT_WIDTH-1:0]    div_dsr;
    logic                      div_done;
    logic [63:0]               div_q;

    logic signed [MEAN_W-1:0]  s_ext;
    logic signed [DELTA_W-1:0] d1_comb;
    logic [DELTA_W-1:0]        ma;
    logic [DELTA_W-1:0]        mb;
    logic [31:0]               op_a;
    logic [31:0]               op_b;
    logic signed [DELTA_W:0]   quo;
    logic [1:0]                col_inc;

    ocov_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start_i    (div_start),
        .dividend_i (div_dvd),
        .divisor_i  (div_dsr),
        .done_o     (div_done),
        .quot_o     (div_q)
    );

    always_comb begin
        state_next = state_reg;
        s_next     = s_reg;
        d1_next    = d1_reg;
        d2_next    = d2_reg;
        mean_next  = mean_reg;
        com_next   = com_reg;
        cov_next   = cov_reg;
        col_next   = col_reg;
        step_next  = step_reg;
        pp_next    = pp_reg;
        sh_next    = sh_reg;
        acc_next   = acc_reg;
        div_start  = 1'b0;
        div_dvd    = '0;
        div_dsr    = count_i - COUNT_WIDTH'(1);
        op_a       = '0;
        op_b       = '0;
        col_inc    = col_reg + 2'd1;
        s_ext      = {sample_i, 16'h0000};
        d1_comb    = {s_ext[MEAN_W-1], s_ext} - {mean_reg[MEAN_W-1], mean_reg};
        ma         = mag_delta(d1_reg);
        mb         = mag_delta(d2_all_i[col_reg]);
        quo        = d1_reg[DELTA_W-1] ? -$signed({1'b0, div_q[DELTA_W-1:0]})
                                       : $signed({1'b0, div_q[DELTA_W-1:0]});

        unique case (state_reg)
            LS_IDLE: begin
                if (ctl_i.clr) begin
                    mean_next = '0;
                    for (int c = 0; c < 3; c++) begin
                        com_next[c] = '0;
                        cov_next[c] = '0;
                    end
                end else if (ctl_i.add) begin
                    s_next     = s_ext;
                    d1_next    = d1_comb;
                    div_start  = 1'b1;
                    div_dvd    = 64'(mag_delta(d1_comb));
                    div_dsr    = count_i;
                    state_next = LS_MDIV;
                end else if (ctl_i.cov) begin
                    if (ctl_i.valid) begin
                        col_next   = 2'd0;
                        div_start  = 1'b1;
                        div_dvd    = mag_cov(com_reg[0]);
                        state_next = LS_CDIV;
                    end else begin
                        for (int c = 0; c < 3; c++) cov_next[c] = '0;
                    end
                end
            end
            LS_MDIV: begin
                if (div_done) begin
                    mean_next  = MEAN_W'({mean_reg[MEAN_W-1], mean_reg[MEAN_W-1], mean_reg}
                                         + quo);
                    state_next = LS_D2;
                end
            end
            LS_D2: begin
                d2_next    = {s_reg[MEAN_W-1], s_reg} - {mean_reg[MEAN_W-1], mean_reg};
                state_next = LS_MWAIT;
            end
            LS_MWAIT: begin
                if (ctl_i.mul) begin
                    col_next   = 2'd0;
                    step_next  = 3'd0;
                    acc_next   = '0;
                    state_next = LS_MUL;
                end
            end
            LS_MUL: begin
                // four 32x32 partial products, each registered and added in the cycle after it is formed
                unique case (step_reg)
                    3'd0: begin
                        op_a = ma[31:0]; op_b = mb[31:0]; sh_next = 2'd0;
                    end
                    3'd1: begin
                        op_a = ma[31:0]; op_b = 32'(mb[DELTA_W-1:32]); sh_next = 2'd1;
                    end
                    3'd2: begin
                        op_a = 32'(ma[DELTA_W-1:32]); op_b = mb[31:0]; sh_next = 2'd1;
                    end
                    3'd3: begin
                        op_a = 32'(ma[DELTA_W-1:32]); op_b = 32'(mb[DELTA_W-1:32]);
                        sh_next = 2'd2;
                    end
                    default: begin
                        op_a = '0; op_b = '0;
                    end
                endcase
                pp_next = 64'(op_a) * 64'(op_b);
                if (step_reg != 3'd0) begin
                    acc_next = acc_reg + (98'(pp_reg) << {sh_reg, 5'b00000});
                end
                step_next = step_reg + 3'd1;
                if (step_reg == 3'd4) begin
                    state_next = LS_MFIN;
                end
            end
            LS_MFIN: begin
                com_next[col_reg] = sat_add(com_reg[col_reg],
                    sat_mag(d1_reg[DELTA_W-1] ^ d2_all_i[col_reg][DELTA_W-1],
                            acc_reg[97:32]));
                if (col_reg == 2'd2) begin
                    state_next = LS_MDONE;
                end else begin
                    col_next   = col_inc;
                    step_next  = 3'd0;
                    acc_next   = '0;
                    state_next = LS_MUL;
                end
            end
            LS_MDONE: begin
                if (ctl_i.cov) begin
                    if (ctl_i.valid) begin
                        col_next   = 2'd0;
                        div_start  = 1'b1;
                        div_dvd    = mag_cov(com_reg[0]);
                        state_next = LS_CDIV;
                    end else begin
                        for (int c = 0; c < 3; c++) cov_next[c] = '0;
                        state_next = LS_IDLE;
                    end
                end
            end
            LS_CDIV: begin
                if (div_done) begin
                    cov_next[col_reg] = sat_mag(com_reg[col_reg][COV_W-1], {2'b00, div_q});
                    if (col_reg == 2'd2) begin
                        state_next = LS_IDLE;
                    end else begin
                        col_next  = col_inc;
                        div_start = 1'b1;
                        div_dvd   = mag_cov(com_reg[col_inc]);
                    end
                end
            end
            default: begin
                state_next = LS_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LS_IDLE;
            mean_reg  <= '0;
            for (int c = 0; c < 3; c++) begin
                com_reg[c] <= '0;
                cov_reg[c] <= '0;
            end
        end else begin
            state_reg <= state_next;
            mean_reg  <= mean_next;
            com_reg   <= com_next;
            cov_reg   <= cov_next;
        end
    end

    always_ff @(posedge aclk) begin
        s_reg    <= s_next;
        d1_reg   <= d1_next;
        d2_reg   <= d2_next;
        col_reg  <= col_next;
        step_reg <= step_next;
        pp_reg   <= pp_next;
        sh_reg   <= sh_next;
        acc_reg  <= acc_next;
    end

    assign stat_o.mean_rdy = (state_reg == LS_MWAIT);
    assign stat_o.mul_done = (state_reg == LS_MDONE);
    assign stat_o.idle     = (state_reg == LS_IDLE);
    assign d2_o            = d2_reg;
    assign mean_o          = mean_reg;
    assign cov_o           = cov_reg;

endmodule

/* hw/rtl/ocov_merge.sv */
// ocov_merge: gathers the lane results and sends them as three row transfers
// depends on ocov_pkg
module ocov_merge (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load_i,
    input  logic signed [47:0]   mean_i [3],
    input  logic signed [63:0]   cov_i [3][3],
    input  logic [19:0]          count_i,
    input  logic                 valid_i,
    output logic                 busy_o,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [247:0]         m_tdata,
    output logic                 m_tlast
);
    import ocov_pkg::*;

    logic                      busy_reg;
    logic [1:0]                row_reg;
    logic signed [SAMPLE_W-1:0] mean_reg [3];
    logic signed [COV_W-1:0]    cov_reg [3][3];
    logic [CNT_OUT_W-1:0]       cnt_reg;
    logic                       vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            row_reg  <= 2'd0;
        end else if (load_i && !busy_reg) begin
            busy_reg <= 1'b1;
            row_reg  <= 2'd0;
        end else if (busy_reg && m_tready) begin
            if (row_reg == ROW_LAST) begin
                busy_reg <= 1'b0;
            end else begin
                row_reg <= row_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_i && !busy_reg) begin
            for (int r = 0; r < 3; r++) mean_reg[r] <= round_mean(mean_i[r]);
            cov_reg <= cov_i;
            cnt_reg <= count_i;
            vld_reg <= valid_i;
        end
    end

    assign busy_o   = busy_reg;
    assign m_tvalid = busy_reg;
    assign m_tlast  = (row_reg == ROW_LAST);
    assign m_tdata  = {1'b0, vld_reg, cnt_reg, cov_reg[row_reg][2], cov_reg[row_reg][1],
                       cov_reg[row_reg][0], mean_reg[row_reg], row_reg};

endmodule

/* hw/rtl/online_covariance_3d.sv */
// online_covariance_3d: streaming welford mean and 3x3 covariance of 3-d points
// an add transfer passes through each lane's 64-step radix-2 divider once for the mean
// and, once the count exceeds one, three times for the covariance row before its rows;
// a clear skips the dividers, and an add at full count uses them only for the covariance row
// one command is in the lanes at a time; the next command is taken while the rows drain
// reset: synchronous active-low aresetn clears count, means and co-moments
module online_covariance_3d #(
    parameter int COUNT_WIDTH = ocov_pkg::COUNT_WIDTH_DEF
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [95:0]   s_tdata,   // sample_x, sample_y, sample_z
    input  logic          s_tuser,   // cmd
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [247:0]  m_tdata,   // row, mean_value, cov_with_x, cov_with_y,
                                     // cov_with_z, sample_count, valid_res, zero pad
    output logic          m_tlast    // last
);
    import ocov_pkg::*;

    top_state_t             state_reg, state_next;
    logic [COUNT_WIDTH-1:0] count_reg, count_next;
    logic signed [31:0]     smp_reg [3];
    logic signed [31:0]     smp_next [3];

    lane_ctl_t              ctl;
    lane_stat_t             stat [3];
    logic signed [48:0]     d2_all [3];
    logic signed [47:0]     mean_all [3];
    logic signed [63:0]     cov_all [3][3];
    logic [2:0]             rdy_vec;
    logic [2:0]             mdone_vec;
    logic [2:0]             idle_vec;
    logic                   accept;
    logic                   merge_busy;
    logic                   merge_load;

    // input transfer only in idle: one command in the lanes at a time
    assign s_tready = (state_reg == T_IDLE);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        count_next = count_reg;
        smp_next   = smp_reg;
        merge_load = 1'b0;
        unique case (state_reg)
            T_IDLE: begin
                if (accept) begin
                    if (s_tuser == CMD_CLEAR) begin
                        count_next = '0;
                        state_next = T_COV;
                    end else if (count_reg == '1) begin
                        // full count: state kept, rows still sent
                        state_next = T_COV;
                    end else begin
                        count_next  = count_reg + COUNT_WIDTH'(1);
                        smp_next[0] = s_tdata[31:0];
                        smp_next[1] = s_tdata[63:32];
                        smp_next[2] = s_tdata[95:64];
                        state_next  = T_ADD;
                    end
                end
            end
            T_ADD:   state_next = T_MEANW;
            T_MEANW: if (&rdy_vec) state_next = T_MULW;
            T_MULW:  if (&mdone_vec) state_next = T_COV;
            T_COV:   state_next = T_COVW;
            T_COVW: begin
                if ((&idle_vec) && !merge_busy) begin
                    merge_load = 1'b1;
                    state_next = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            count_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        smp_reg <= smp_next;
    end

    // lane control shared by all three axes
    assign ctl.add   = (state_reg == T_ADD);
    assign ctl.clr   = accept && (s_tuser == CMD_CLEAR);
    assign ctl.mul   = (state_reg == T_MEANW) && (&rdy_vec);
    assign ctl.cov   = (state_reg == T_COV);
    assign ctl.valid = (count_reg > COUNT_WIDTH'(1));

    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        ocov_lane #(.COUNT_WIDTH(COUNT_WIDTH)) u_lane (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl_i    (ctl),
            .sample_i (smp_reg[g]),
            .count_i  (count_reg),
            .d2_all_i (d2_all),
            .stat_o   (stat[g]),
            .d2_o     (d2_all[g]),
            .mean_o   (mean_all[g]),
            .cov_o    (cov_all[g])
        );
        assign rdy_vec[g]   = stat[g].mean_rdy;
        assign mdone_vec[g] = stat[g].mul_done;
        assign idle_vec[g]  = stat[g].idle;
    end

    // merging stage: the row transfers wait here while the lanes take the next command
    ocov_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load_i   (merge_load),
        .mean_i   (mean_all),
        .cov_i    (cov_all),
        .count_i  (CNT_OUT_W'(count_reg)),
        .valid_i  (ctl.valid),
        .busy_o   (merge_busy),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* hw/rtl/ocov_checker.sv */
// ocov_checker: port-level checks of the online covariance block, bound to the top level
// depends on online_covariance_3d ports only
module ocov_checker (
    input logic          aclk,
    input logic          aresetn,
    input logic          s_tvalid,
    input logic          s_tready,
    input logic          m_tvalid,
    input logic          m_tready,
    input logic [247:0]  m_tdata,
    input logic          m_tlast
);

    // a stalled row holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("row changed while stalled");

    // rows of one command follow without gaps
    a_row_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast
        |=> m_tvalid && (m_tdata[1:0] == $past(m_tdata[1:0]) + 2'd1))
        else $error("row sequence broken");

    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tdata[1:0] == 2'd2)))
        else $error("tlast not on row two");

    a_zero_cov: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[246] |-> (m_tdata[225:34] == '0))
        else $error("covariance shown without valid flag");

    a_one_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second command taken while busy");

endmodule

bind online_covariance_3d ocov_checker u_ocov_checker (.*);
